// ===== src/stok_pkg.sv =====
// ----------------------------------------------------------------------------
// stok_pkg
// Shared types, token kinds and keyword tables for the source tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

    localparam int POS_BITS_DEFAULT = 16;
    localparam int KW_MAX_LEN_DEFAULT = 6;
    localparam int MAX_RES = 3;
    localparam int NUM_KW = 10;
    localparam int KW_TEXT_LEN = 6;

    typedef logic [4:0] kind_t;

    localparam kind_t K_LPAREN = 5'd0;
    localparam kind_t K_RPAREN = 5'd1;
    localparam kind_t K_PLUS = 5'd2;
    localparam kind_t K_MINUS = 5'd3;
    localparam kind_t K_COMMA = 5'd4;
    localparam kind_t K_SLASH = 5'd5;
    localparam kind_t K_STAR = 5'd6;
    localparam kind_t K_BANG = 5'd7;
    localparam kind_t K_GREATER = 5'd9;
    localparam kind_t K_LESSER = 5'd11;
    localparam kind_t K_EQUAL = 5'd13;
    localparam kind_t K_STRING = 5'd15;
    localparam kind_t K_IDENT = 5'd16;
    localparam kind_t K_NUMBER = 5'd17;
    localparam kind_t K_KW_BASE = 5'd18;
    localparam kind_t K_EOF = 5'd28;
    localparam kind_t K_ERR_CHAR = 5'd29;
    localparam kind_t K_ERR_STRING = 5'd30;

    localparam logic [7:0] KW_TEXT [0:NUM_KW-1][0:KW_TEXT_LEN-1] = '{
        '{"a", "n", "d", 8'h00, 8'h00, 8'h00},
        '{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"d", "e", "f", 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "i", "f", 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"t", "h", "e", "n", 8'h00, 8'h00},
        '{"l", "e", "t", 8'h00, 8'h00, 8'h00},
        '{"e", "n", "d", 8'h00, 8'h00, 8'h00},
        '{"e", "x", "t", "e", "r", "n"}
    };
    localparam logic [2:0] KW_LEN [0:NUM_KW-1] = '{
        3'd3, 3'd2, 3'd3, 3'd2, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd6
    };

    typedef struct packed {
        kind_t       kind;
        logic [15:0] start_pos;
        logic [15:0] end_pos;
        logic [15:0] line;
        logic        last_of_run;
    } tok_res_t;

    typedef struct packed {
        logic [1:0]                 count;
        tok_res_t [MAX_RES-1:0]     res;
    } tok_batch_t;

endpackage

// ===== src/stok_in_if.sv =====
// ----------------------------------------------------------------------------
// stok_in_if
// Byte channel into the tokenizer.
// ----------------------------------------------------------------------------
interface stok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_source;

    modport source (output valid, output ch, output end_of_source, input ready);
    modport sink (input valid, input ch, input end_of_source, output ready);
endinterface

// ===== src/stok_out_if.sv =====
// ----------------------------------------------------------------------------
// stok_out_if
// Token channel out of the tokenizer.
// ----------------------------------------------------------------------------
interface stok_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  kind;
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    logic [15:0] line;
    logic        last_of_run;

    modport source (output valid, output kind, output start_pos, output end_pos,
                    output line, output last_of_run, input ready);
    modport sink (input valid, input kind, input start_pos, input end_pos,
                  input line, input last_of_run, output ready);
endinterface

// ===== src/stok_scan.sv =====
// ----------------------------------------------------------------------------
// stok_scan
// Scanner state and next-state logic; forms up to three tokens per byte.
// ----------------------------------------------------------------------------
module stok_scan #(
    parameter int POS_BITS = stok_pkg::POS_BITS_DEFAULT,
    parameter int KEYWORD_MAX_LEN = stok_pkg::KW_MAX_LEN_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           ch,
    input  logic                 end_of_source,
    output stok_pkg::tok_batch_t batch
);

    localparam int LW = $clog2(KEYWORD_MAX_LEN + 2);
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    typedef enum logic [3:0] {
        M_IDLE, M_OP, M_SLASH, M_COMMENT, M_STRING, M_IDENT, M_NUM, M_NUM_DOT, M_NUM_FRAC
    } mode_t;

    mode_t               mode_reg, mode_next;
    logic [POS_BITS-1:0] token_start_reg, token_start_next;
    logic [POS_BITS-1:0] byte_pos_reg, byte_pos_next;
    logic [15:0]         line_reg, line_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [7:0]          pending_reg, pending_next;
    logic [7:0]          kwbuf_reg [KEYWORD_MAX_LEN];
    logic [7:0]          kwbuf_next [KEYWORD_MAX_LEN];

    function automatic logic [15:0] out_pos(input logic [POS_BITS-1:0] v);
        logic [POS_BITS+15:0] ext;
        ext = {16'd0, v};
        return ext[15:0];
    endfunction

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? POS_MAX : v + 1'b1;
    endfunction

    function automatic logic [POS_BITS-1:0] sat_dec(input logic [POS_BITS-1:0] v);
        return (v == '0) ? '0 : v - 1'b1;
    endfunction

    function automatic stok_pkg::tok_res_t mk(input stok_pkg::kind_t k,
                                              input logic [POS_BITS-1:0] s,
                                              input logic [POS_BITS-1:0] e,
                                              input logic [15:0] ln);
        stok_pkg::tok_res_t r;
        r.kind = k;
        r.start_pos = out_pos(s);
        r.end_pos = out_pos(e);
        r.line = ln;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    logic [POS_BITS-1:0] p, p_inc, p_dec, ts, ts_inc;
    stok_pkg::kind_t     op_one, id_kind;
    logic                is_alpha, is_digit, do_start, kw_hit;
    logic [1:0]          n;
    stok_pkg::tok_res_t  r [stok_pkg::MAX_RES];

    assign p = byte_pos_reg;
    assign p_inc = sat_inc(byte_pos_reg);
    assign p_dec = sat_dec(byte_pos_reg);
    assign ts = token_start_reg;
    assign ts_inc = sat_inc(token_start_reg);
    assign is_alpha = (ch inside {["a":"z"], ["A":"Z"]});
    assign is_digit = (ch inside {["0":"9"]});

    always_comb
    begin
        case (pending_reg)
            "!":     op_one = stok_pkg::K_BANG;
            ">":     op_one = stok_pkg::K_GREATER;
            "<":     op_one = stok_pkg::K_LESSER;
            default: op_one = stok_pkg::K_EQUAL;
        endcase
    end

    always_comb
    begin
        id_kind = stok_pkg::K_IDENT;
        for (int k = stok_pkg::NUM_KW - 1; k >= 0; k--)
        begin
            kw_hit = (len_reg == LW'(stok_pkg::KW_LEN[k]));
            for (int j = 0; j < stok_pkg::KW_TEXT_LEN; j++)
            begin
                if (j < int'(stok_pkg::KW_LEN[k]) && kwbuf_reg[j] != stok_pkg::KW_TEXT[k][j])
                begin
                    kw_hit = 1'b0;
                end
            end
            if (kw_hit)
            begin
                id_kind = stok_pkg::K_KW_BASE + 5'(k);
            end
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        token_start_next = token_start_reg;
        byte_pos_next = byte_pos_reg;
        line_next = line_reg;
        len_next = len_reg;
        pending_next = pending_reg;
        kwbuf_next = kwbuf_reg;
        n = 2'd0;
        do_start = 1'b0;
        for (int i = 0; i < stok_pkg::MAX_RES; i++)
        begin
            r[i] = '0;
        end

        if (end_of_source)
        begin
            case (mode_reg)
                M_OP:
                begin
                    r[n] = mk(op_one, ts, ts_inc, line_reg);
                    n = n + 2'd1;
                end
                M_SLASH:
                begin
                    r[n] = mk(stok_pkg::K_SLASH, ts, ts_inc, line_reg);
                    n = n + 2'd1;
                end
                M_STRING:
                begin
                    r[n] = mk(stok_pkg::K_ERR_STRING, p_dec, p_dec, line_reg);
                    n = n + 2'd1;
                end
                M_IDENT:
                begin
                    r[n] = mk(id_kind, ts, p, line_reg);
                    n = n + 2'd1;
                end
                M_NUM, M_NUM_FRAC:
                begin
                    r[n] = mk(stok_pkg::K_NUMBER, ts, p, line_reg);
                    n = n + 2'd1;
                end
                M_NUM_DOT:
                begin
                    r[n] = mk(stok_pkg::K_NUMBER, ts, p_dec, line_reg);
                    n = n + 2'd1;
                    r[n] = mk(stok_pkg::K_ERR_CHAR, p_dec, p_dec, line_reg);
                    n = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            r[n] = mk(stok_pkg::K_EOF, p, p, line_reg);
            n = n + 2'd1;
            mode_next = M_IDLE;
            token_start_next = '0;
            byte_pos_next = '0;
            line_next = 16'd1;
            len_next = '0;
        end
        else
        begin
            case (mode_reg)
                M_OP:
                begin
                    if (ch == "=")
                    begin
                        r[n] = mk(op_one + 5'd1, ts, p_inc, line_reg);
                        n = n + 2'd1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        r[n] = mk(op_one, ts, ts_inc, line_reg);
                        n = n + 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (ch == "/")
                    begin
                        mode_next = M_COMMENT;
                    end
                    else
                    begin
                        r[n] = mk(stok_pkg::K_SLASH, ts, ts_inc, line_reg);
                        n = n + 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    do_start = (ch == 8'h0a) || (ch == 8'h00);
                end
                M_STRING:
                begin
                    if (ch == "\"")
                    begin
                        r[n] = mk(stok_pkg::K_STRING, ts_inc, p, line_reg);
                        n = n + 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if (ch == 8'h0a && line_reg != 16'hffff)
                    begin
                        line_next = line_reg + 16'd1;
                    end
                end
                M_IDENT:
                begin
                    if (is_alpha || is_digit || ch == "_")
                    begin
                        for (int i = 0; i < KEYWORD_MAX_LEN; i++)
                        begin
                            if (len_reg == LW'(i))
                            begin
                                kwbuf_next[i] = ch;
                            end
                        end
                        if (len_reg <= LW'(KEYWORD_MAX_LEN))
                        begin
                            len_next = len_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        r[n] = mk(id_kind, ts, p, line_reg);
                        n = n + 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_NUM:
                begin
                    if (ch == ".")
                    begin
                        mode_next = M_NUM_DOT;
                    end
                    else if (!is_digit)
                    begin
                        r[n] = mk(stok_pkg::K_NUMBER, ts, p, line_reg);
                        n = n + 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_NUM_DOT:
                begin
                    if (is_digit)
                    begin
                        mode_next = M_NUM_FRAC;
                    end
                    else
                    begin
                        r[n] = mk(stok_pkg::K_NUMBER, ts, p_dec, line_reg);
                        n = n + 2'd1;
                        r[n] = mk(stok_pkg::K_ERR_CHAR, p_dec, p_dec, line_reg);
                        n = n + 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_NUM_FRAC:
                begin
                    if (!is_digit)
                    begin
                        r[n] = mk(stok_pkg::K_NUMBER, ts, p, line_reg);
                        n = n + 2'd1;
                        do_start = 1'b1;
                    end
                end
                default:
                begin
                    do_start = 1'b1;
                end
            endcase
            byte_pos_next = p_inc;

            if (do_start)
            begin
                token_start_next = p;
                mode_next = M_IDLE;
                case (ch)
                    8'h0a:
                    begin
                        if (line_reg != 16'hffff)
                        begin
                            line_next = line_reg + 16'd1;
                        end
                    end
                    " ", 8'h0d, 8'h09:
                    begin
                    end
                    "(":
                    begin
                        r[n] = mk(stok_pkg::K_LPAREN, p, p_inc, line_reg);
                        n = n + 2'd1;
                    end
                    ")":
                    begin
                        r[n] = mk(stok_pkg::K_RPAREN, p, p_inc, line_reg);
                        n = n + 2'd1;
                    end
                    "+":
                    begin
                        r[n] = mk(stok_pkg::K_PLUS, p, p_inc, line_reg);
                        n = n + 2'd1;
                    end
                    "-":
                    begin
                        r[n] = mk(stok_pkg::K_MINUS, p, p_inc, line_reg);
                        n = n + 2'd1;
                    end
                    ",":
                    begin
                        r[n] = mk(stok_pkg::K_COMMA, p, p_inc, line_reg);
                        n = n + 2'd1;
                    end
                    "*":
                    begin
                        r[n] = mk(stok_pkg::K_STAR, p, p_inc, line_reg);
                        n = n + 2'd1;
                    end
                    "!", "<", ">", "=":
                    begin
                        pending_next = ch;
                        mode_next = M_OP;
                    end
                    "/":
                    begin
                        mode_next = M_SLASH;
                    end
                    "\"":
                    begin
                        mode_next = M_STRING;
                    end
                    default:
                    begin
                        if (is_alpha || ch == "_")
                        begin
                            kwbuf_next[0] = ch;
                            len_next = LW'(1);
                            mode_next = M_IDENT;
                        end
                        else if (is_digit)
                        begin
                            mode_next = M_NUM;
                        end
                        else
                        begin
                            r[n] = mk(stok_pkg::K_ERR_CHAR, p, p, line_reg);
                            n = n + 2'd1;
                        end
                    end
                endcase
            end
        end

        if (n != 2'd0)
        begin
            r[n - 2'd1].last_of_run = 1'b1;
        end
        batch.count = n;
        for (int i = 0; i < stok_pkg::MAX_RES; i++)
        begin
            batch.res[i] = r[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            token_start_reg <= '0;
            byte_pos_reg <= '0;
            line_reg <= 16'd1;
            len_reg <= '0;
            pending_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            token_start_reg <= token_start_next;
            byte_pos_reg <= byte_pos_next;
            line_reg <= line_next;
            len_reg <= len_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kwbuf_reg <= kwbuf_next;
        end
    end

endmodule

// ===== src/stok_rbuf.sv =====
// ----------------------------------------------------------------------------
// stok_rbuf
// Result register: holds the tokens of one byte and hands them out in order.
// ----------------------------------------------------------------------------
module stok_rbuf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  stok_pkg::tok_batch_t batch,
    output logic                 free,
    stok_out_if.source           tok_out
);

    stok_pkg::tok_res_t [stok_pkg::MAX_RES-1:0] res_reg;
    logic [1:0] cnt_reg;
    logic [1:0] rd_reg;
    logic       pop;

    assign tok_out.valid = (cnt_reg != 2'd0);
    assign pop = tok_out.valid && tok_out.ready;
    assign free = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && tok_out.ready);

    assign tok_out.kind = res_reg[rd_reg].kind;
    assign tok_out.start_pos = res_reg[rd_reg].start_pos;
    assign tok_out.end_pos = res_reg[rd_reg].end_pos;
    assign tok_out.line = res_reg[rd_reg].line;
    assign tok_out.last_of_run = res_reg[rd_reg].last_of_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= batch.count;
            rd_reg <= 2'd0;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
            rd_reg <= rd_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= batch.res;
        end
    end

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
        else $error("load while tokens pending");
    a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_out.valid && cnt_reg == 2'd1) |-> tok_out.last_of_run)
        else $error("final token lacks last_of_run");
    a_last_early: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg > 2'd1) |-> !tok_out.last_of_run)
        else $error("last_of_run before final token");
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (load && batch.count != 2'd0) |=> tok_out.valid)
        else $error("loaded tokens not shown");

endmodule

// ===== src/source_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexical scanner: one source byte per word in, tokens out.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the result register is free. The scanner
// state is updated in the cycle a byte is taken and its tokens (zero to three)
// land in a result register. The next byte is let in only once that register
// is empty or the output takes its last token; until then the input is held
// while the register drains, one token per cycle while the output is ready.
module source_tokenizer #(
    parameter int POS_BITS = stok_pkg::POS_BITS_DEFAULT,
    parameter int KEYWORD_MAX_LEN = stok_pkg::KW_MAX_LEN_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    stok_in_if.sink    tok_in,
    stok_out_if.source tok_out
);

    stok_pkg::tok_batch_t batch;
    logic                 free;
    logic                 accept;

    assign tok_in.ready = free;
    assign accept = tok_in.valid && free;

    stok_scan #(
        .POS_BITS(POS_BITS),
        .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
    ) u_scan (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .ch(tok_in.ch),
        .end_of_source(tok_in.end_of_source),
        .batch(batch)
    );

    stok_rbuf u_rbuf (
        .clk(clk),
        .rst_n(rst_n),
        .load(accept),
        .batch(batch),
        .free(free),
        .tok_out(tok_out)
    );

endmodule

// ===== tb/source_tokenizer_test.sv =====
// ----------------------------------------------------------------------------
// source_tokenizer_test
// Self-checking bench for the source tokenizer: a directed table of bytes and
// end-of-source words, then random token-shaped text, with every token checked
// against a scanner model kept in the bench. Both channels idle at random.
// ----------------------------------------------------------------------------
module source_tokenizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        SC_IDLE, SC_OP, SC_SLASH, SC_COMMENT, SC_STRING,
        SC_IDENT, SC_NUM, SC_NUM_DOT, SC_NUM_FRAC
    } scan_t;

    localparam logic [15:0] POS_TOP = 16'hFFFF;
    localparam stok_pkg::kind_t K_BANG_EQ = 5'd8;
    localparam stok_pkg::kind_t K_GREATER_EQ = 5'd10;
    localparam stok_pkg::kind_t K_LESSER_EQ = 5'd12;
    localparam stok_pkg::kind_t K_EQUAL_EQ = 5'd14;

    typedef struct {
        logic [7:0]         ch;
        logic               eos;
        logic               typed;
        stok_pkg::tok_res_t tok;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors = 0;
    bit   feeding_done = 1'b0;

    stok_in_if  byte_ch ();
    stok_out_if tok_ch ();

    source_tokenizer dut (.clk(clk), .rst_n(rst_n), .tok_in(byte_ch), .tok_out(tok_ch));

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // scanner model state
    scan_t              sc_mode;
    logic [15:0]        sc_start;
    logic [15:0]        sc_pos;
    logic [15:0]        sc_line;
    logic [7:0]         sc_kw [0:5];
    int                 sc_len;
    logic [7:0]         sc_op;
    stok_pkg::tok_res_t tokens_due [$];
    stok_pkg::tok_res_t run_toks [$];

    function automatic logic [15:0] up1(logic [15:0] v);
        return (v == POS_TOP) ? v : v + 16'd1;
    endfunction

    function automatic logic [15:0] dn1(logic [15:0] v);
        return (v == 16'd0) ? v : v - 16'd1;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic push_tok(stok_pkg::kind_t k, logic [15:0] s, logic [15:0] e);
        stok_pkg::tok_res_t t;
        t.kind = k;
        t.start_pos = s;
        t.end_pos = e;
        t.line = sc_line;
        t.last_of_run = 1'b0;
        run_toks.insert(run_toks.size(), t);
    endtask

    task automatic op_tok(bit two, logic [15:0] s, logic [15:0] e);
        stok_pkg::kind_t k;
        case (sc_op)
            "!": k = two ? K_BANG_EQ : stok_pkg::K_BANG;
            ">": k = two ? K_GREATER_EQ : stok_pkg::K_GREATER;
            "<": k = two ? K_LESSER_EQ : stok_pkg::K_LESSER;
            default: k = two ? K_EQUAL_EQ : stok_pkg::K_EQUAL;
        endcase
        push_tok(k, s, e);
    endtask

    task automatic ident_tok(logic [15:0] e);
        stok_pkg::kind_t k;
        bit              same;
        k = stok_pkg::K_IDENT;
        if (sc_len <= 6)
        begin
            for (int i = 0; i < stok_pkg::NUM_KW; i++)
            begin
                same = (sc_len == int'(stok_pkg::KW_LEN[i]));
                for (int j = 0; j < sc_len && j < 6; j++)
                    if (sc_kw[j] != stok_pkg::KW_TEXT[i][j])
                        same = 1'b0;
                if (same && k == stok_pkg::K_IDENT)
                    k = stok_pkg::K_KW_BASE + stok_pkg::kind_t'(i);
            end
        end
        push_tok(k, sc_start, e);
    endtask

    task automatic begin_lexeme(logic [7:0] c, logic [15:0] p);
        sc_start = p;
        sc_mode = SC_IDLE;
        case (c)
            8'h0a: if (sc_line != POS_TOP) sc_line++;
            " ", 8'h0d, 8'h09: ;
            "(": push_tok(stok_pkg::K_LPAREN, p, up1(p));
            ")": push_tok(stok_pkg::K_RPAREN, p, up1(p));
            "+": push_tok(stok_pkg::K_PLUS, p, up1(p));
            "-": push_tok(stok_pkg::K_MINUS, p, up1(p));
            ",": push_tok(stok_pkg::K_COMMA, p, up1(p));
            "*": push_tok(stok_pkg::K_STAR, p, up1(p));
            "!", "<", ">", "=":
            begin
                sc_op = c;
                sc_mode = SC_OP;
            end
            "/": sc_mode = SC_SLASH;
            "\"": sc_mode = SC_STRING;
            default:
                if (is_letter(c) || c == "_")
                begin
                    sc_kw[0] = c;
                    sc_len = 1;
                    sc_mode = SC_IDENT;
                end
                else if (is_num(c))
                    sc_mode = SC_NUM;
                else
                    push_tok(stok_pkg::K_ERR_CHAR, p, p);
        endcase
    endtask

    task automatic scan_word(logic [7:0] c, logic eos);
        logic [15:0] p;
        p = sc_pos;
        run_toks.delete();
        if (eos)
        begin
            case (sc_mode)
                SC_OP: op_tok(1'b0, sc_start, up1(sc_start));
                SC_SLASH: push_tok(stok_pkg::K_SLASH, sc_start, up1(sc_start));
                SC_STRING: push_tok(stok_pkg::K_ERR_STRING, dn1(p), dn1(p));
                SC_IDENT: ident_tok(p);
                SC_NUM, SC_NUM_FRAC: push_tok(stok_pkg::K_NUMBER, sc_start, p);
                SC_NUM_DOT:
                begin
                    push_tok(stok_pkg::K_NUMBER, sc_start, dn1(p));
                    push_tok(stok_pkg::K_ERR_CHAR, dn1(p), dn1(p));
                end
                default: ;
            endcase
            push_tok(stok_pkg::K_EOF, p, p);
            sc_mode = SC_IDLE;
            sc_start = 16'd0;
            sc_pos = 16'd0;
            sc_line = 16'd1;
            sc_len = 0;
        end
        else
        begin
            case (sc_mode)
                SC_OP:
                    if (c == "=")
                    begin
                        op_tok(1'b1, sc_start, up1(p));
                        sc_mode = SC_IDLE;
                    end
                    else
                    begin
                        op_tok(1'b0, sc_start, up1(sc_start));
                        begin_lexeme(c, p);
                    end
                SC_SLASH:
                    if (c == "/")
                        sc_mode = SC_COMMENT;
                    else
                    begin
                        push_tok(stok_pkg::K_SLASH, sc_start, up1(sc_start));
                        begin_lexeme(c, p);
                    end
                SC_COMMENT:
                    if (c == 8'h0a || c == 8'h00)
                        begin_lexeme(c, p);
                SC_STRING:
                    if (c == "\"")
                    begin
                        push_tok(stok_pkg::K_STRING, up1(sc_start), p);
                        sc_mode = SC_IDLE;
                    end
                    else if (c == 8'h0a && sc_line != POS_TOP)
                        sc_line++;
                SC_IDENT:
                    if (is_letter(c) || is_num(c) || c == "_")
                    begin
                        if (sc_len < 6)
                            sc_kw[sc_len] = c;
                        if (sc_len <= 6)
                            sc_len++;
                    end
                    else
                    begin
                        ident_tok(p);
                        begin_lexeme(c, p);
                    end
                SC_NUM, SC_NUM_FRAC:
                    if (c == "." && sc_mode == SC_NUM)
                        sc_mode = SC_NUM_DOT;
                    else if (!is_num(c))
                    begin
                        push_tok(stok_pkg::K_NUMBER, sc_start, p);
                        begin_lexeme(c, p);
                    end
                SC_NUM_DOT:
                    if (is_num(c))
                        sc_mode = SC_NUM_FRAC;
                    else
                    begin
                        push_tok(stok_pkg::K_NUMBER, sc_start, dn1(p));
                        push_tok(stok_pkg::K_ERR_CHAR, dn1(p), dn1(p));
                        begin_lexeme(c, p);
                    end
                default: begin_lexeme(c, p);
            endcase
            sc_pos = up1(p);
        end
        if (run_toks.size() > 0)
            run_toks[run_toks.size() - 1].last_of_run = 1'b1;
    endtask

    // stimulus store
    logic [7:0]         byte_q [$];
    logic               eos_q [$];
    logic               typed_q [$];
    stok_pkg::tok_res_t typed_tok_q [$];

    task automatic add_byte(logic [7:0] c);
        byte_q.insert(byte_q.size(), c);
        eos_q.insert(eos_q.size(), 1'b0);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_eos();
        byte_q.insert(byte_q.size(), 8'($urandom_range(255, 0)));
        eos_q.insert(eos_q.size(), 1'b1);
    endtask

    function automatic stok_pkg::tok_res_t mk(stok_pkg::kind_t k, int s, int e, int l);
        stok_pkg::tok_res_t t;
        t.kind = k;
        t.start_pos = 16'(s);
        t.end_pos = 16'(e);
        t.line = 16'(l);
        t.last_of_run = 1'b1;
        return t;
    endfunction

    function automatic string rand_lexeme();
        string s;
        string kws [10];
        kws = '{"and", "or", "def", "if", "elif", "else", "then", "let", "end", "extern"};
        s = "";
        case ($urandom_range(9, 0))
            0: s = kws[$urandom_range(9, 0)];
            1: repeat ($urandom_range(9, 1))
                   s = {s, string'(8'($urandom_range(25, 0) + "a"))};
            2:
            begin
                repeat ($urandom_range(4, 1))
                    s = {s, string'(8'($urandom_range(9, 0) + "0"))};
                if ($urandom_range(1, 0))
                    s = {s, "."};
                if ($urandom_range(2, 0))
                    s = {s, "7"};
            end
            3: s = "\"ab\ncd\"";
            4: s = "// note\n";
            5: s = "!=";
            6:
            begin
                if ($urandom_range(1, 0) != 0)
                    s = "<";
                else
                    s = ">=";
            end
            7:
            begin
                if ($urandom_range(1, 0) != 0)
                    s = "(+)";
                else
                    s = "-,*/";
            end
            8: s = "\n";
            default: s = "_x9";
        endcase
        if ($urandom_range(2, 0) != 0)
            s = {s, " "};
        return s;
    endfunction

    // directed table, directed text, then random lexemes; source "(" reads one token at once
    task automatic build_stimulus();
        row_t table_rows [$];
        row_t r;
        string s;
        table_rows.insert(table_rows.size(),
                          '{"(", 1'b0, 1'b1, mk(stok_pkg::K_LPAREN, 0, 1, 1)});
        table_rows.insert(table_rows.size(),
                          '{8'hff, 1'b0, 1'b1, mk(stok_pkg::K_ERR_CHAR, 1, 1, 1)});
        table_rows.insert(table_rows.size(),
                          '{8'h80, 1'b0, 1'b1, mk(stok_pkg::K_ERR_CHAR, 2, 2, 1)});
        table_rows.insert(table_rows.size(),
                          '{8'h00, 1'b0, 1'b1, mk(stok_pkg::K_ERR_CHAR, 3, 3, 1)});
        table_rows.insert(table_rows.size(),
                          '{8'h00, 1'b1, 1'b1, mk(stok_pkg::K_EOF, 4, 4, 1)});
        foreach (table_rows[i])
        begin
            r = table_rows[i];
            byte_q.insert(byte_q.size(), r.ch);
            eos_q.insert(eos_q.size(), r.eos);
            typed_q.insert(typed_q.size(), r.typed);
            typed_tok_q.insert(typed_tok_q.size(), r.tok);
        end
        add_text("x!=1.5<=a>b==c=d!e");
        add_text("12.x 3.\"s\n\"//c");
        add_byte(8'h00);
        add_text("extern externs  then/ 4.");
        add_eos();
        add_text("\"open");
        add_eos();
        add_text("ab");
        add_eos();
        add_text("<");
        add_eos();
        add_text("/");
        add_eos();
        add_text("9.");
        add_eos();
        add_eos();
        while (byte_q.size() < 360)
        begin
            if ($urandom_range(9, 0) == 0)
                add_byte(8'($urandom_range(255, 0)));
            else
            begin
                s = rand_lexeme();
                add_text(s);
            end
            if ($urandom_range(39, 0) == 0)
                add_eos();
        end
        add_text("ab 1.");
        add_eos();
    endtask

    function automatic int gap_len();
        int n;
        n = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 5) : $urandom_range(2, 0);
        if ($urandom_range(3, 0) == 0)
            n = 0;
        return n;
    endfunction

    initial
    begin
        int gap;
        byte_ch.valid = 1'b0;
        byte_ch.ch = 8'h00;
        byte_ch.end_of_source = 1'b0;
        sc_mode = SC_IDLE;
        sc_start = 16'd0;
        sc_pos = 16'd0;
        sc_line = 16'd1;
        sc_len = 0;
        sc_op = 8'h00;
        build_stimulus();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < byte_q.size(); i++)
        begin
            byte_ch.valid <= 1'b1;
            byte_ch.ch <= byte_q[i];
            byte_ch.end_of_source <= eos_q[i];
            @(posedge clk);
            while (!byte_ch.ready)
                @(posedge clk);
            scan_word(byte_q[i], eos_q[i]);
            if (i < typed_q.size() && typed_q[i])
                if (run_toks.size() != 1 || run_toks[0] != typed_tok_q[i])
                begin
                    $display("%0t table row %0d: expected %p, model %p", $time, i,
                             typed_tok_q[i], run_toks);
                    errors++;
                end
            foreach (run_toks[j])
                tokens_due.insert(tokens_due.size(), run_toks[j]);
            gap = gap_len();
            if (gap != 0 || i == byte_q.size() - 1)
                byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        feeding_done = 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_ch.ready <= 1'b0;
        else
            tok_ch.ready <= ($urandom_range(19, 0) == 0) ? 1'b0 : ($urandom_range(3, 0) != 0);
    end

    always @(posedge clk)
    begin
        stok_pkg::tok_res_t seen;
        stok_pkg::tok_res_t want;
        if (rst_n && tok_ch.valid && tok_ch.ready)
        begin
            seen.kind = tok_ch.kind;
            seen.start_pos = tok_ch.start_pos;
            seen.end_pos = tok_ch.end_pos;
            seen.line = tok_ch.line;
            seen.last_of_run = tok_ch.last_of_run;
            if (tokens_due.size() == 0)
            begin
                $display("%0t unexpected token: expected none, actual %p", $time, seen);
                errors++;
            end
            else
            begin
                want = tokens_due.pop_front();
                if (seen.kind != want.kind)
                begin
                    $display("%0t kind: expected %0d, actual %0d", $time, want.kind, seen.kind);
                    errors++;
                end
                if (seen.start_pos != want.start_pos)
                begin
                    $display("%0t start_pos: expected %0d, actual %0d", $time,
                             want.start_pos, seen.start_pos);
                    errors++;
                end
                if (seen.end_pos != want.end_pos)
                begin
                    $display("%0t end_pos: expected %0d, actual %0d", $time,
                             want.end_pos, seen.end_pos);
                    errors++;
                end
                if (seen.line != want.line)
                begin
                    $display("%0t line: expected %0d, actual %0d", $time, want.line, seen.line);
                    errors++;
                end
                if (seen.last_of_run != want.last_of_run)
                begin
                    $display("%0t last_of_run: expected %0d, actual %0d", $time,
                             want.last_of_run, seen.last_of_run);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        wait (feeding_done);
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
